// ===== rtl/qwsc_pkg.sv =====
// Shared constants and fixed-point helpers for the quarter-wave sine/cosine generator.
package qwsc_pkg;

    // pi/2 in unsigned Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int              Q30_BITS    = 30;

    function automatic longint unsigned mul_q30(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b) >> Q30_BITS;
    endfunction

    // Subtract and floor at zero.
    function automatic longint unsigned sub_floor(input longint unsigned a,
                                                  input longint unsigned b);
        return (a >= b) ? (a - b) : 64'd0;
    endfunction

endpackage

// ===== rtl/quarter_wave_sin_cos_interp.sv =====
// Quarter-wave sine/cosine generator with linear interpolation between table entries.
//
// Takes one phase beat per clock while in_stall is low (a PHASE_BITS unsigned fraction of a
// full turn) and returns its sine and cosine in signed Q1.(OUT_BITS-1), saturated to
// +/-(2^(OUT_BITS-1)-1). The throughput is one beat per cycle when nothing stalls. The phase
// is captured in an input register, and one combinational pass (quadrant fold, table index,
// two table reads and one interpolation multiply per output) feeds the result register. The
// quarter-wave table of TABLE_ENTRIES entries is a constant built at elaboration, so there
// is no load or clearing time after reset. An input beat is taken while a finished result
// waits under stall, as long as the input register is free.
module quarter_wave_sin_cos_interp #(
    parameter int TABLE_ENTRIES = 257,
    parameter int PHASE_BITS    = 16,
    parameter int OUT_BITS      = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PHASE_BITS-1:0]      phase,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] sine,
    output logic signed [OUT_BITS-1:0] cosine
);

    import qwsc_pkg::*;

    localparam int POS_BITS  = PHASE_BITS - 2;
    localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
    localparam int S_BITS    = POS_BITS + IDX_BITS;
    localparam int MAG_BITS  = OUT_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + POS_BITS;
    localparam int LAST      = TABLE_ENTRIES - 1;

    localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(LAST);
    localparam logic [S_BITS-1:0]   FULL_SPAN = S_BITS'(LAST) << POS_BITS;

    // table build constants
    localparam longint unsigned SPAN        = longint'(LAST);
    localparam longint unsigned HALF_SPAN   = SPAN / 2;
    localparam int              TABLE_SHIFT = 31 - OUT_BITS;
    localparam longint unsigned ROUND_HALF  = 64'd1 << (TABLE_SHIFT - 1);
    localparam longint unsigned TOP_VAL     = (64'd1 << MAG_BITS) - 64'd1;

    typedef struct packed {
        logic [IDX_BITS-1:0] i0;
        logic [IDX_BITS-1:0] i1;
        logic [POS_BITS-1:0] frac;
    } qpos_t;

    // Taylor series of sin(k * pi/2 / LAST) in Q2.30, terms up to x^21.
    function automatic longint unsigned table_value(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(k) * HALF_PI_Q30 + HALF_SPAN) / SPAN;
        x2   = mul_q30(x, x);
        term = x;
        sum  = x;
        term = mul_q30(term, x2) / 6;   sum = sub_floor(sum, term);
        term = mul_q30(term, x2) / 20;  sum = sum + term;
        term = mul_q30(term, x2) / 42;  sum = sub_floor(sum, term);
        term = mul_q30(term, x2) / 72;  sum = sum + term;
        term = mul_q30(term, x2) / 110; sum = sub_floor(sum, term);
        term = mul_q30(term, x2) / 156; sum = sum + term;
        term = mul_q30(term, x2) / 210; sum = sub_floor(sum, term);
        term = mul_q30(term, x2) / 272; sum = sum + term;
        term = mul_q30(term, x2) / 342; sum = sub_floor(sum, term);
        term = mul_q30(term, x2) / 420; sum = sum + term;
        v = (sum + ROUND_HALF) >> TABLE_SHIFT;
        if (v > TOP_VAL)
        begin
            v = TOP_VAL;
        end
        return v;
    endfunction

    // Fold the position into the table; mirror about the end of the quarter.
    function automatic qpos_t place_of(input logic [POS_BITS-1:0] pos, input logic mirror);
        logic [S_BITS-1:0] s;
        qpos_t             r;
        s = S_BITS'(pos) * S_BITS'(LAST);
        if (mirror)
        begin
            s = FULL_SPAN - s;
        end
        r.i0   = s[S_BITS-1:POS_BITS];
        r.frac = s[POS_BITS-1:0];
        // clamp the upper neighbor to the last entry
        r.i1   = (r.i0 == LAST_IDX) ? r.i0 : r.i0 + IDX_BITS'(1);
        return r;
    endfunction

    function automatic logic [MAG_BITS-1:0] interp(input logic [MAG_BITS-1:0] y0,
                                                   input logic [MAG_BITS-1:0] y1,
                                                   input logic [POS_BITS-1:0] frac);
        logic [MAG_BITS-1:0]  hi;
        logic [PROD_BITS-1:0] prod;
        hi   = (y1 < y0) ? y0 : y1;
        prod = PROD_BITS'(hi - y0) * PROD_BITS'(frac);
        return y0 + prod[PROD_BITS-1:POS_BITS];
    endfunction

    function automatic logic [OUT_BITS-1:0] apply_sign(input logic [MAG_BITS-1:0] mag,
                                                       input logic negative);
        logic [OUT_BITS-1:0] m;
        m = {1'b0, mag};
        return negative ? (OUT_BITS'(0) - m) : m;
    endfunction

    logic [MAG_BITS-1:0] rom [TABLE_ENTRIES];

    for (genvar k = 0; k < TABLE_ENTRIES; k++)
    begin : g_rom
        assign rom[k] = MAG_BITS'(table_value(k));
    end

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [OUT_BITS-1:0] sine_reg;
    logic signed [OUT_BITS-1:0] cosine_reg;
    logic [OUT_BITS-1:0]        sine_next;
    logic [OUT_BITS-1:0]        cosine_next;

    logic                       out_ready;
    logic                       load_s1;
    logic                       move_s1;
    logic [1:0]                 quad;
    logic [POS_BITS-1:0]        pos;
    qpos_t                      sin_pos;
    qpos_t                      cos_pos;
    logic [MAG_BITS-1:0]        sin_mag;
    logic [MAG_BITS-1:0]        cos_mag;

    assign out_ready = !out_valid_reg || !out_stall;
    assign move_s1   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign load_s1   = in_valid && !in_stall;

    assign s1_valid_next  = load_s1 || (s1_valid_reg && !move_s1);
    assign out_valid_next = move_s1 || (out_valid_reg && out_stall);

    always_comb
    begin
        quad    = phase_reg[PHASE_BITS-1 -: 2];
        pos     = phase_reg[POS_BITS-1:0];
        // sine mirrors in odd quadrants, cosine in even ones
        sin_pos = place_of(pos, quad[0]);
        cos_pos = place_of(pos, !quad[0]);
        sin_mag = interp(rom[sin_pos.i0], rom[sin_pos.i1], sin_pos.frac);
        cos_mag = interp(rom[cos_pos.i0], rom[cos_pos.i1], cos_pos.frac);
        sine_next   = apply_sign(sin_mag, quad[1]);
        cosine_next = apply_sign(cos_mag, quad[1] ^ quad[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            phase_reg <= phase;
        end
        if (move_s1)
        begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(phase_reg))
        else $error("blocked input beat was lost or changed");

    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sine_reg != {1'b1, {MAG_BITS{1'b0}}})
        else $error("sine reached the most negative code");

    a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> cosine_reg != {1'b1, {MAG_BITS{1'b0}}})
        else $error("cosine reached the most negative code");

    a_zero_phase: assert property (@(posedge clk) disable iff (!rst_n)
        move_s1 && phase_reg == '0 |=>
            sine_reg == '0 && cosine_reg == OUT_BITS'(rom[TABLE_ENTRIES-1]))
        else $error("zero phase did not give sine 0 and cosine full scale");

    a_first_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
        move_s1 && phase_reg[PHASE_BITS-1 -: 2] == 2'b00 |=>
            !sine_reg[OUT_BITS-1] && !cosine_reg[OUT_BITS-1])
        else $error("negative result in the first quadrant");

endmodule
